// File: hdl/seek_flee_arrival_steering_defines.svh
// assertion macros for the seek/flee steering block
// no dependencies; included by the top level
`ifndef SEEK_FLEE_ARRIVAL_STEERING_DEFINES_SVH
`define SEEK_FLEE_ARRIVAL_STEERING_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SFAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sfas_pkg.sv
// shared constants for the seek/flee steering block
// no dependencies
`default_nettype none
package sfas_pkg;
  localparam int FIELD_W = 24;
  localparam int CFG_W   = 23;
  localparam int IM_W    = 13;
  localparam int IDX_W   = 3;
  localparam int SUB_W   = 28;

  localparam logic [IDX_W-1:0] CFG_MAX_VELOCITY   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_FORCE      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MAX_SPEED      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_INVERSE_MASS   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ARRIVAL_RADIUS = 3'd4;

  localparam logic [CFG_W-1:0] RST_MAX_VELOCITY   = 23'd8192;
  localparam logic [CFG_W-1:0] RST_MAX_FORCE      = 23'd819;
  localparam logic [CFG_W-1:0] RST_MAX_SPEED      = 23'd12288;
  localparam logic [IM_W-1:0]  RST_INVERSE_MASS   = 13'd410;
  localparam logic [CFG_W-1:0] RST_ARRIVAL_RADIUS = 23'd40960;
endpackage
`default_nettype wire

// File: hdl/sfas_csub.sv
// shared compare-subtract unit for the square root and divider steps
// uses sfas_pkg for the default width
`default_nettype none
module sfas_csub #(
  parameter int W = sfas_pkg::SUB_W
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              ge,
  output logic [W-1:0]      diff
);
  logic [W:0] d;
  assign d    = {1'b0, a} - {1'b0, b};
  assign ge   = ~d[W];
  assign diff = d[W-1:0];
endmodule
`default_nettype wire

// File: hdl/seek_flee_arrival_steering.sv
// One steering step per input beat: offset to target, distance by an iterative square root
// outside the arrival radius, desired velocity by two bit-serial divides (skipped at zero
// distance), clamped steering and velocity, new position. One shared 24x24 multiplier and
// one shared compare-subtract unit do the work under a sequencer; the block takes one beat
// at a time. The square root takes 25 steps and each divide 48 steps per axis through the
// compare-subtract unit. A finished result waits in the output register while the next beat
// is taken. Depends on sfas_pkg, sfas_csub and the defines header.
`default_nettype none
`include "seek_flee_arrival_steering_defines.svh"
module seek_flee_arrival_steering (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [23:0] in_target_x,
  input  wire logic [23:0] in_target_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_pos_x,
  output logic [23:0]      out_pos_y,
  output logic [23:0]      out_vel_x,
  output logic [23:0]      out_vel_y,
  output logic [23:0]      out_heading_x,
  output logic [23:0]      out_heading_y,
  output logic             out_inside_radius,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_data
);
  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_SQX  = 17'h00002, S_SQY  = 17'h00004, S_SQR  = 17'h00008,
    S_CMP  = 17'h00010, S_SQRT = 17'h00020, S_MULX = 17'h00040, S_DIVX = 17'h00080,
    S_STX  = 17'h00100, S_MSX  = 17'h00200, S_VX   = 17'h00400, S_MULY = 17'h00800,
    S_DIVY = 17'h01000, S_STY  = 17'h02000, S_MSY  = 17'h04000, S_VY   = 17'h08000,
    S_DONE = 17'h10000
  } state_t;

  state_t state_r;
  logic [22:0] mv_r, mf_r, ms_r, rad_r;
  logic [12:0] im_r;
  logic signed [23:0] px_r, py_r, vx_r, vy_r;
  logic [23:0] ux_r, uy_r;
  logic negx_r, negy_r, inside_r, zdist_r;
  logic [47:0] p_r;
  logic [49:0] d2_r, wrk_r;
  logic [27:0] rem_r;
  logic [24:0] root_r, dvs_r;
  logic [5:0]  cnt_r;
  logic signed [23:0] s_r, nvx_r, nvy_r;
  logic out_valid_r;
  logic [23:0] o_px_r, o_py_r, o_vx_r, o_vy_r, o_hx_r, o_hy_r;
  logic o_in_r;

  // accept path
  logic signed [24:0] dx, dy, ax, ay;
  assign dx = $signed({in_target_x[23], in_target_x}) - $signed({px_r[23], px_r});
  assign dy = $signed({in_target_y[23], in_target_y}) - $signed({py_r[23], py_r});
  assign ax = dx[24] ? -dx : dx;
  assign ay = dy[24] ? -dy : dy;

  // shared multiplier
  logic [23:0] mul_a, mul_b, s_mag;
  logic [47:0] mul_p;
  assign s_mag = s_r[23] ? 24'(-s_r) : 24'(s_r);
  always_comb begin
    unique case (state_r)
      S_SQX:        begin mul_a = ux_r;          mul_b = ux_r; end
      S_SQY:        begin mul_a = uy_r;          mul_b = uy_r; end
      S_SQR:        begin mul_a = {1'b0, rad_r}; mul_b = {1'b0, rad_r}; end
      S_MULX:       begin mul_a = ux_r;          mul_b = {1'b0, mv_r}; end
      S_MULY:       begin mul_a = uy_r;          mul_b = {1'b0, mv_r}; end
      S_MSX, S_MSY: begin mul_a = s_mag;         mul_b = {11'b0, im_r}; end
      default:      begin mul_a = '0;            mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // shared compare-subtract
  logic [27:0] sub_a, sub_b, sub_diff;
  logic sub_ge;
  always_comb begin
    if (state_r == S_SQRT) begin
      sub_a = {rem_r[25:0], wrk_r[49:48]};
      sub_b = {1'b0, root_r, 2'b01};
    end else begin
      sub_a = {2'b0, rem_r[24:0], wrk_r[47]};
      sub_b = {3'b0, dvs_r};
    end
  end
  sfas_csub #(.W(sfas_pkg::SUB_W)) u_csub (
    .a(sub_a), .b(sub_b), .ge(sub_ge), .diff(sub_diff)
  );

  // steering clamp
  logic st_neg;
  logic signed [23:0] st_v;
  logic signed [48:0] dv;
  logic signed [49:0] st_diff, st_lim;
  logic signed [23:0] st_c;
  assign st_neg  = (state_r == S_STY) ? negy_r : negx_r;
  assign st_v    = (state_r == S_STY) ? vy_r : vx_r;
  assign dv      = st_neg ? -$signed({1'b0, wrk_r[47:0]}) : $signed({1'b0, wrk_r[47:0]});
  assign st_diff = $signed({dv[48], dv}) - $signed({{26{st_v[23]}}, st_v});
  assign st_lim  = $signed({27'b0, mf_r});
  always_comb begin
    if (st_diff > st_lim) st_c = 24'(st_lim);
    else if (st_diff < -st_lim) st_c = 24'(-st_lim);
    else st_c = 24'(st_diff);
  end

  // velocity update
  logic signed [23:0] vu_v;
  logic signed [24:0] sx;
  logic signed [25:0] vsum, vlim;
  logic signed [23:0] nv;
  assign vu_v = (state_r == S_VY) ? vy_r : vx_r;
  assign sx   = s_r[23] ? -$signed({1'b0, p_r[35:12]}) : $signed({1'b0, p_r[35:12]});
  assign vsum = $signed({{2{vu_v[23]}}, vu_v}) + $signed({sx[24], sx});
  assign vlim = $signed({3'b0, ms_r});
  always_comb begin
    if (vsum > vlim) nv = 24'(vlim);
    else if (vsum < -vlim) nv = 24'(-vlim);
    else nv = 24'(vsum);
  end

  // position saturation
  logic signed [24:0] psx, psy;
  logic [23:0] npx, npy;
  assign psx = $signed({px_r[23], px_r}) + $signed({nvx_r[23], nvx_r});
  assign psy = $signed({py_r[23], py_r}) + $signed({nvy_r[23], nvy_r});
  assign npx = (psx[24] != psx[23]) ? (psx[24] ? 24'h800000 : 24'h7fffff) : psx[23:0];
  assign npy = (psy[24] != psy[23]) ? (psy[24] ? 24'h800000 : 24'h7fffff) : psy[23:0];

  logic done_go;
  assign done_go  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mv_r        <= sfas_pkg::RST_MAX_VELOCITY;
      mf_r        <= sfas_pkg::RST_MAX_FORCE;
      ms_r        <= sfas_pkg::RST_MAX_SPEED;
      im_r        <= sfas_pkg::RST_INVERSE_MASS;
      rad_r       <= sfas_pkg::RST_ARRIVAL_RADIUS;
      px_r        <= '0;
      py_r        <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfas_pkg::CFG_MAX_VELOCITY:   mv_r  <= cfg_data;
          sfas_pkg::CFG_MAX_FORCE:      mf_r  <= cfg_data;
          sfas_pkg::CFG_MAX_SPEED:      ms_r  <= cfg_data;
          sfas_pkg::CFG_INVERSE_MASS:   im_r  <= cfg_data[12:0];
          sfas_pkg::CFG_ARRIVAL_RADIUS: rad_r <= cfg_data;
          default: ;
        endcase
      end
      if (done_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ux_r    <= ax[23:0];
            uy_r    <= ay[23:0];
            negx_r  <= dx[24] ^ in_mode;
            negy_r  <= dy[24] ^ in_mode;
            state_r <= S_SQX;
          end
        end
        S_SQX: begin p_r <= mul_p; state_r <= S_SQY; end
        S_SQY: begin d2_r <= {2'b0, p_r}; p_r <= mul_p; state_r <= S_SQR; end
        S_SQR: begin d2_r <= d2_r + {2'b0, p_r}; p_r <= mul_p; state_r <= S_CMP; end
        S_CMP: begin
          inside_r <= d2_r < {2'b0, p_r};
          zdist_r  <= 1'b0;
          rem_r    <= '0;
          root_r   <= '0;
          if (d2_r < {2'b0, p_r}) begin
            dvs_r   <= {2'b0, rad_r};
            state_r <= S_MULX;
          end else begin
            wrk_r   <= d2_r;
            cnt_r   <= 6'd24;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem_r  <= sub_ge ? sub_diff : sub_a;
          root_r <= {root_r[23:0], sub_ge};
          wrk_r  <= {wrk_r[47:0], 2'b00};
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            dvs_r <= {root_r[23:0], sub_ge};
            if ({root_r[23:0], sub_ge} == 25'd0) begin
              zdist_r <= 1'b1;
              wrk_r   <= '0;
              state_r <= S_STX;
            end else begin
              state_r <= S_MULX;
            end
          end
        end
        S_MULX, S_MULY: begin
          wrk_r   <= {2'b0, mul_p};
          rem_r   <= '0;
          cnt_r   <= 6'd47;
          state_r <= (state_r == S_MULX) ? S_DIVX : S_DIVY;
        end
        S_DIVX, S_DIVY: begin
          rem_r <= sub_ge ? sub_diff : sub_a;
          wrk_r <= {2'b0, wrk_r[46:0], sub_ge};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= (state_r == S_DIVX) ? S_STX : S_STY;
        end
        S_STX: begin s_r <= st_c; state_r <= S_MSX; end
        S_STY: begin s_r <= st_c; state_r <= S_MSY; end
        S_MSX: begin p_r <= mul_p; state_r <= S_VX; end
        S_MSY: begin p_r <= mul_p; state_r <= S_VY; end
        S_VX: begin
          nvx_r <= nv;
          if (zdist_r) state_r <= S_STY;
          else state_r <= S_MULY;
        end
        S_VY: begin nvy_r <= nv; state_r <= S_DONE; end
        S_DONE: begin
          if (done_go) begin
            o_px_r  <= npx;
            o_py_r  <= npy;
            o_vx_r  <= nvx_r;
            o_vy_r  <= nvy_r;
            o_hx_r  <= vx_r;
            o_hy_r  <= vy_r;
            o_in_r  <= inside_r;
            px_r    <= npx;
            py_r    <= npy;
            vx_r    <= nvx_r;
            vy_r    <= nvy_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = o_px_r;
  assign out_pos_y         = o_py_r;
  assign out_vel_x         = o_vx_r;
  assign out_vel_y         = o_vy_r;
  assign out_heading_x     = o_hx_r;
  assign out_heading_y     = o_hy_r;
  assign out_inside_radius = o_in_r;

  `SFAS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_SQX, "accept did not start a step")
  `SFAS_ASSERT_NOW(a_div_nonzero, state_r == S_DIVX || state_r == S_DIVY, dvs_r != 25'd0, "divide by zero")
  `SFAS_ASSERT_NOW(a_out_from_done, $rose(out_valid_r), $past(state_r == S_DONE), "result without a finished step")
endmodule
`default_nettype wire

// File: tb/tb_seek_flee_arrival_steering.sv
// Self-checking bench for seek_flee_arrival_steering: steering targets in, new kinematics out.
// Drives targets with burst gaps and a stalling receiver, predicts each step internally.
// Depends on sfas_pkg and the seek_flee_arrival_steering RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_seek_flee_arrival_steering;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    bit mode;
    logic [23:0] tx;
    logic [23:0] ty;
  } target_t;

  typedef struct {
    logic [23:0] px, py, vx, vy, hx, hy;
    logic in_rad;
  } kin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire in_ready;
  logic in_mode = 1'b0;
  logic [23:0] in_target_x = '0;
  logic [23:0] in_target_y = '0;
  wire out_valid;
  logic out_ready = 1'b0;
  wire [23:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_heading_x, out_heading_y;
  wire out_inside_radius;
  logic cfg_valid = 1'b0;
  wire cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;

  seek_flee_arrival_steering DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and settings
  longint vel_max, force_max, speed_max, inv_mass, radius;
  longint agent_px, agent_py, agent_vx, agent_vy;

  target_t target_q[$];
  kin_t expected_steps[$];
  int errors = 0;
  int steps_done = 0;
  int inside_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  bit in_took = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic kin_t steer_step(target_t t);
    kin_t k;
    longint tx, ty, dx, dy, ux, uy, d2, len, dvx, dvy, sx, sy;
    bit in_rad;
    tx = longint'($signed(t.tx));
    ty = longint'($signed(t.ty));
    dx = tx - agent_px;
    dy = ty - agent_py;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    d2 = ux * ux + uy * uy;
    in_rad = d2 < radius * radius;
    if (t.mode) begin
      dx = -dx;
      dy = -dy;
    end
    if (in_rad) begin
      dvx = dx * vel_max / radius;
      dvy = dy * vel_max / radius;
    end else begin
      len = longint'(int_sqrt(d2));
      if (len == 0) begin
        dvx = 0;
        dvy = 0;
      end else begin
        dvx = dx * vel_max / len;
        dvy = dy * vel_max / len;
      end
    end
    sx = clamp_sym(dvx - agent_vx, force_max) * inv_mass / 4096;
    sy = clamp_sym(dvy - agent_vy, force_max) * inv_mass / 4096;
    k.hx = agent_vx[23:0];
    k.hy = agent_vy[23:0];
    agent_vx = clamp_sym(agent_vx + sx, speed_max);
    agent_vy = clamp_sym(agent_vy + sy, speed_max);
    agent_px = sat24(agent_px + agent_vx);
    agent_py = sat24(agent_py + agent_vy);
    k.px = agent_px[23:0];
    k.py = agent_py[23:0];
    k.vx = agent_vx[23:0];
    k.vy = agent_vy[23:0];
    k.in_rad = in_rad;
    return k;
  endfunction

  // sender: bursts with random gaps
  int gap = 0;
  int burst = 0;
  always @(negedge clk) begin
    target_t t;
    if (rst_n && (!in_valid || in_took)) begin
      in_took = 1'b0;
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (target_q.size() != 0) begin
        t = target_q.pop_front();
        in_mode <= t.mode;
        in_target_x <= t.tx;
        in_target_y <= t.ty;
        in_valid <= 1'b1;
        if (burst > 0) begin
          burst--;
        end else begin
          burst = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int rdy_mode = 0;
  int rdy_cnt = 0;
  always @(negedge clk) begin
    if (rdy_cnt == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_cnt = $urandom_range(20, 200);
    end
    rdy_cnt--;
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    kin_t e;
    target_t t;
    idle_cycles++;
    if (rst_n && in_valid && in_ready) begin
      t.mode = in_mode;
      t.tx = in_target_x;
      t.ty = in_target_y;
      expected_steps.push_back(steer_step(t));
      in_took = 1'b1;
      idle_cycles = 0;
    end
    if (rst_n && out_valid && out_ready) begin
      idle_cycles = 0;
      if (expected_steps.size() == 0) begin
        $error("result beat with no step pending");
        errors++;
      end else begin
        e = expected_steps.pop_front();
        steps_done++;
        if (e.in_rad) inside_seen++;
        if (out_pos_x !== e.px) begin
          $error("pos_x exp %h got %h", e.px, out_pos_x); errors++;
        end
        if (out_pos_y !== e.py) begin
          $error("pos_y exp %h got %h", e.py, out_pos_y); errors++;
        end
        if (out_vel_x !== e.vx) begin
          $error("vel_x exp %h got %h", e.vx, out_vel_x); errors++;
        end
        if (out_vel_y !== e.vy) begin
          $error("vel_y exp %h got %h", e.vy, out_vel_y); errors++;
        end
        if (out_heading_x !== e.hx) begin
          $error("heading_x exp %h got %h", e.hx, out_heading_x); errors++;
        end
        if (out_heading_y !== e.hy) begin
          $error("heading_y exp %h got %h", e.hy, out_heading_y); errors++;
        end
        if (out_inside_radius !== e.in_rad) begin
          $error("inside_radius exp %b got %b", e.in_rad, out_inside_radius); errors++;
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d steps pending", idle_cycles,
               expected_steps.size());
      $display("tb_seek_flee_arrival_steering: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[22:0];
    do @(posedge clk); while (!cfg_ready);
    idle_cycles = 0;
    case (idx)
      sfas_pkg::CFG_MAX_VELOCITY:   vel_max = val & 23'h7fffff;
      sfas_pkg::CFG_MAX_FORCE:      force_max = val & 23'h7fffff;
      sfas_pkg::CFG_MAX_SPEED:      speed_max = val & 23'h7fffff;
      sfas_pkg::CFG_INVERSE_MASS:   inv_mass = val & 13'h1fff;
      sfas_pkg::CFG_ARRIVAL_RADIUS: radius = val & 23'h7fffff;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(longint mv, longint mf, longint ms, longint im, longint ar);
    write_reg(sfas_pkg::CFG_MAX_VELOCITY, mv);
    write_reg(sfas_pkg::CFG_MAX_FORCE, mf);
    write_reg(sfas_pkg::CFG_MAX_SPEED, ms);
    write_reg(sfas_pkg::CFG_INVERSE_MASS, im);
    write_reg(sfas_pkg::CFG_ARRIVAL_RADIUS, ar);
    settings_used++;
  endtask

  task automatic push(bit m, longint x, longint y);
    target_t t;
    t.mode = m;
    t.tx = x[23:0];
    t.ty = y[23:0];
    target_q.push_back(t);
  endtask

  task automatic drain();
    while (target_q.size() != 0 || expected_steps.size() != 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_steps(int n);
    longint span, ox, oy;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      span = radius * 2 + 16;
      if (span > 4194304) span = 4194304;
      if (kind < 4) begin
        ox = longint'($urandom_range(0, span * 2)) - span;
        oy = longint'($urandom_range(0, span * 2)) - span;
        push($urandom_range(0, 3) == 0, sat24(agent_px + ox), sat24(agent_py + oy));
      end else if (kind < 8) begin
        push($urandom_range(0, 1), $urandom, $urandom);
      end else if (kind == 8) begin
        push($urandom_range(0, 1), $urandom_range(0, 1) ? 8388607 : -8388608,
             $urandom_range(0, 1) ? 8388607 : -8388608);
      end else begin
        push($urandom_range(0, 1), agent_px, agent_py);
      end
      if (i % 8 == 7) while (target_q.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    vel_max = sfas_pkg::RST_MAX_VELOCITY;
    force_max = sfas_pkg::RST_MAX_FORCE;
    speed_max = sfas_pkg::RST_MAX_SPEED;
    inv_mass = sfas_pkg::RST_INVERSE_MASS;
    radius = sfas_pkg::RST_ARRIVAL_RADIUS;
    agent_px = 0; agent_py = 0; agent_vx = 0; agent_vy = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero offset, radius boundary, extremes, both modes
    push(0, 0, 0);
    push(1, 0, 0);
    push(0, 40960, 0);
    drain();
    push(0, agent_px + 40959, agent_py);
    push(1, agent_px, agent_py - 40960);
    push(0, 8388607, 8388607);
    push(1, -8388608, -8388608);
    push(0, 8388607, -8388608);
    push(1, -8388608, 8388607);
    push(0, 0, 0);
    push(1, 1, -1);
    drain();

    // extreme settings: saturating position, heavy mass factor
    set_all(8388607, 8388607, 8388607, 8191, 8388607);
    for (int i = 0; i < 6; i++) push(i[0], 8388607, -8388608);
    push(0, 0, 0);
    push(1, 0, 0);
    drain();
    set_all(0, 0, 0, 0, 0);
    push(0, 123456, -654321);
    push(1, agent_px, agent_py);
    drain();
    set_all(8192, 819, 12288, 4096, 1);
    push(0, agent_px, agent_py);
    push(0, agent_px + 1, agent_py);
    drain();
    random_steps(60);

    set_all(sfas_pkg::RST_MAX_VELOCITY, sfas_pkg::RST_MAX_FORCE, sfas_pkg::RST_MAX_SPEED,
            sfas_pkg::RST_INVERSE_MASS, sfas_pkg::RST_ARRIVAL_RADIUS);
    random_steps(150);
    set_all(8388607, 8388607, 8388607, 8191, 8388607);
    random_steps(120);
    set_all(0, 8388607, 8388607, 4096, 0);
    random_steps(100);
    for (int p = 0; p < 5; p++) begin
      set_all($urandom_range(0, 8388607) >> $urandom_range(0, 12),
              $urandom_range(0, 8388607) >> $urandom_range(0, 14),
              $urandom_range(0, 8388607) >> $urandom_range(0, 10),
              $urandom_range(0, 8191),
              $urandom_range(1, 8388607) >> $urandom_range(0, 16));
      random_steps(130);
    end
    set_all(8388607, 1, 8388607, 1, 8388607);
    random_steps(40);

    drain();
    repeat (200) @(posedge clk);
    $display("checked %0d steering steps over %0d register settings, %0d inside radius",
             steps_done, settings_used, inside_seen);
    if (errors == 0) begin
      $display("tb_seek_flee_arrival_steering: done, clean");
    end else begin
      $display("tb_seek_flee_arrival_steering: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/sfas_pkg.sv
hdl/sfas_csub.sv
hdl/seek_flee_arrival_steering.sv
tb/tb_seek_flee_arrival_steering.sv
